// ===== design/assert_macros.svh =====
// Assertion macros shared by the gate RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, masked while reset is held
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("omcg assertion failed");

// Clocked property, checked during reset as well
`define ASSERT_PROP_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("omcg assertion failed");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_PROP_NR(label, clk, prop)

`endif

`endif

// ===== design/omcg_pkg.sv =====
// Package: codes, permission matrix and bundle types of the mode gate
`timescale 1ns / 1ps

package omcg_pkg;

    typedef enum logic [2:0] {
        MODE_INIT       = 3'd0,
        MODE_IDLE       = 3'd1,
        MODE_WASHING    = 3'd2,
        MODE_MANUAL     = 3'd3,
        MODE_SELFCHECK  = 3'd4,
        MODE_EXCEPTION  = 3'd5,
        MODE_RECOVERING = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        KIND_COMMAND        = 4'd0,
        KIND_WASH_START     = 4'd1,
        KIND_WASH_DONE      = 4'd2,
        KIND_WASH_ABORT     = 4'd3,
        KIND_POST_WASH      = 4'd4,
        KIND_SELFCHECK_DONE = 4'd5,
        KIND_CRITICAL       = 4'd6,
        KIND_ESTOP          = 4'd7,
        KIND_ESTOP_CLEAR    = 4'd8,
        KIND_RECOVERY_DONE  = 4'd9,
        KIND_FAULT_RESET    = 4'd10,
        KIND_SERVICE_SET    = 4'd11,
        KIND_INIT           = 4'd12
    } t_kind;

    typedef enum logic [3:0] {
        CMD_VOID          = 4'd0,
        CMD_WASH_GO       = 4'd1,
        CMD_WASH_HALT     = 4'd2,
        CMD_STOP_OP       = 4'd3,
        CMD_RESUME_OP     = 4'd4,
        CMD_FAULT_CLR     = 4'd5,
        CMD_HOME          = 4'd6,
        CMD_MANUAL_ON     = 4'd7,
        CMD_MANUAL_ACT    = 4'd8,
        CMD_START_CHECK   = 4'd9,
        CMD_RESTORE       = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_ALLOWED = 2'd0,
        VERDICT_DENIED  = 2'd1,
        VERDICT_EVENT   = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        REASON_NONE        = 3'd0,
        REASON_UNKNOWN_CMD = 3'd1,
        REASON_WRONG_MODE  = 3'd2,
        REASON_ESTOP       = 3'd3,
        REASON_SERVICE_OFF = 3'd4
    } t_reason;

    typedef enum logic [1:0] {
        PERM_NO   = 2'd0,
        PERM_YES  = 2'd1,
        PERM_COND = 2'd2
    } t_perm;

    localparam int NumCmdRows = 11;
    localparam int NumModes   = 7;

    // rows: command code, columns: mode
    localparam t_perm PERM_TABLE [NumCmdRows][NumModes] = '{
        '{PERM_NO, PERM_NO,   PERM_NO,  PERM_NO,   PERM_NO, PERM_NO,   PERM_NO},
        '{PERM_NO, PERM_YES,  PERM_NO,  PERM_NO,   PERM_NO, PERM_NO,   PERM_NO},
        '{PERM_NO, PERM_NO,   PERM_YES, PERM_NO,   PERM_NO, PERM_NO,   PERM_NO},
        '{PERM_NO, PERM_YES,  PERM_NO,  PERM_NO,   PERM_NO, PERM_NO,   PERM_NO},
        '{PERM_NO, PERM_YES,  PERM_NO,  PERM_NO,   PERM_NO, PERM_NO,   PERM_NO},
        '{PERM_NO, PERM_COND, PERM_NO,  PERM_NO,   PERM_NO, PERM_COND, PERM_NO},
        '{PERM_NO, PERM_NO,   PERM_NO,  PERM_NO,   PERM_NO, PERM_YES,  PERM_NO},
        '{PERM_NO, PERM_YES,  PERM_NO,  PERM_NO,   PERM_NO, PERM_NO,   PERM_NO},
        '{PERM_NO, PERM_NO,   PERM_NO,  PERM_YES,  PERM_NO, PERM_YES,  PERM_NO},
        '{PERM_NO, PERM_COND, PERM_NO,  PERM_NO,   PERM_NO, PERM_COND, PERM_NO},
        '{PERM_NO, PERM_NO,   PERM_NO,  PERM_COND, PERM_NO, PERM_COND, PERM_NO}
    };

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] command;
        logic       alarm_blocking;
        logic       abort_was_manual;
        logic       exc_demand;
        logic       recovery_to_idle;
        logic       service_enable;
    } t_req;

    typedef struct packed {
        t_mode mode;
        logic  estop;
        logic  service;
    } t_state;

    typedef struct packed {
        t_verdict verdict;
        t_reason  reject_reason;
        t_mode    mode;
        t_mode    previous_mode;
        logic     mode_changed;
        logic     recovery_requested;
        logic     context_sync;
        logic     estop_latched;
        logic     service_on;
        logic     stopping;
        logic     standby;
    } t_rsp;

endpackage

// ===== design/omcg_if.sv =====
// Request and result channel interfaces of the mode gate
`timescale 1ns / 1ps

interface omcg_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [3:0] command;
    logic       alarm_blocking;
    logic       abort_was_manual;
    logic       exc_demand;
    logic       recovery_to_idle;
    logic       service_enable;

    modport source (
        output valid, kind, command, alarm_blocking, abort_was_manual,
               exc_demand, recovery_to_idle, service_enable,
        input  ready
    );
    modport sink (
        input  valid, kind, command, alarm_blocking, abort_was_manual,
               exc_demand, recovery_to_idle, service_enable,
        output ready
    );
endinterface

interface omcg_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [2:0] reject_reason;
    logic [2:0] mode;
    logic [2:0] previous_mode;
    logic       mode_changed;
    logic       recovery_requested;
    logic       context_sync;
    logic       estop_latched;
    logic       service_on;
    logic       stopping;
    logic       standby;

    modport source (
        output valid, verdict, reject_reason, mode, previous_mode, mode_changed,
               recovery_requested, context_sync, estop_latched, service_on,
               stopping, standby,
        input  ready
    );
    modport sink (
        input  valid, verdict, reject_reason, mode, previous_mode, mode_changed,
               recovery_requested, context_sync, estop_latched, service_on,
               stopping, standby,
        output ready
    );
endinterface

// ===== design/omcg_judge.sv =====
// Command check: permission matrix lookup plus estop, service and alarm checks
`timescale 1ns / 1ps

module omcg_judge (
    input  logic [3:0]        i_command,
    input  logic              i_alarm_blocking,
    input  omcg_pkg::t_state  i_state,
    output omcg_pkg::t_reason o_reason
);

    always_comb begin
        omcg_pkg::t_perm perm;
        logic [3:0]      row;
        logic [2:0]      col;

        row      = i_command;
        col      = i_state.mode;
        perm     = omcg_pkg::PERM_NO;
        o_reason = omcg_pkg::REASON_NONE;

        if (i_command == omcg_pkg::CMD_VOID || i_command > omcg_pkg::CMD_RESTORE) begin
            o_reason = omcg_pkg::REASON_UNKNOWN_CMD;
        end else if (i_state.mode > omcg_pkg::MODE_RECOVERING) begin
            o_reason = omcg_pkg::REASON_WRONG_MODE;
        end else begin
            perm = omcg_pkg::PERM_TABLE[row][col];
            if (perm == omcg_pkg::PERM_NO) begin
                o_reason = omcg_pkg::REASON_WRONG_MODE;
            end else if (perm == omcg_pkg::PERM_COND && i_state.estop) begin
                o_reason = omcg_pkg::REASON_ESTOP;
            end else if (i_command == omcg_pkg::CMD_WASH_GO && !i_state.service) begin
                o_reason = omcg_pkg::REASON_SERVICE_OFF;
            end else if (i_command == omcg_pkg::CMD_WASH_GO && i_alarm_blocking) begin
                o_reason = omcg_pkg::REASON_WRONG_MODE;
            end else if (i_command == omcg_pkg::CMD_RESUME_OP && i_state.service) begin
                // resume only makes sense while service is off
                o_reason = omcg_pkg::REASON_WRONG_MODE;
            end
        end
    end

endmodule

// ===== design/omcg_step.sv =====
// Next-state and result logic for one request
`timescale 1ns / 1ps

module omcg_step (
    input  omcg_pkg::t_req   i_req,
    input  omcg_pkg::t_state i_state,
    output omcg_pkg::t_state o_next,
    output omcg_pkg::t_rsp   o_rsp
);

    omcg_pkg::t_reason reason;

    omcg_judge u_judge (
        .i_command        (i_req.command),
        .i_alarm_blocking (i_req.alarm_blocking),
        .i_state          (i_state),
        .o_reason         (reason)
    );

    always_comb begin
        omcg_pkg::t_mode cur;
        omcg_pkg::t_mode tgt;
        logic            go;
        logic            changed;

        cur     = i_state.mode;
        tgt     = cur;
        go      = 1'b0;
        changed = 1'b0;
        o_next  = i_state;

        o_rsp                    = '0;
        o_rsp.verdict            = omcg_pkg::VERDICT_EVENT;
        o_rsp.reject_reason      = omcg_pkg::REASON_NONE;
        o_rsp.previous_mode      = cur;
        o_rsp.recovery_requested = 1'b0;
        o_rsp.context_sync       = 1'b0;

        unique case (i_req.kind)
            omcg_pkg::KIND_COMMAND: begin
                o_rsp.reject_reason = reason;
                o_rsp.verdict = (reason == omcg_pkg::REASON_NONE) ?
                                omcg_pkg::VERDICT_ALLOWED : omcg_pkg::VERDICT_DENIED;
                if (reason == omcg_pkg::REASON_NONE) begin
                    unique case (i_req.command)
                        omcg_pkg::CMD_MANUAL_ON: begin
                            go  = 1'b1;
                            tgt = omcg_pkg::MODE_MANUAL;
                        end
                        omcg_pkg::CMD_START_CHECK: begin
                            go  = 1'b1;
                            tgt = omcg_pkg::MODE_SELFCHECK;
                        end
                        omcg_pkg::CMD_RESTORE: begin
                            go  = 1'b1;
                            tgt = omcg_pkg::MODE_RECOVERING;
                            o_rsp.recovery_requested = 1'b1;
                        end
                        omcg_pkg::CMD_STOP_OP: begin
                            o_next.service     = 1'b0;
                            o_rsp.context_sync = 1'b1;
                        end
                        omcg_pkg::CMD_RESUME_OP: begin
                            o_next.service     = 1'b1;
                            o_rsp.context_sync = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            omcg_pkg::KIND_WASH_START: begin
                go  = (cur == omcg_pkg::MODE_IDLE);
                tgt = omcg_pkg::MODE_WASHING;
            end
            omcg_pkg::KIND_WASH_DONE: begin
                go  = (cur == omcg_pkg::MODE_WASHING);
                tgt = omcg_pkg::MODE_IDLE;
            end
            omcg_pkg::KIND_WASH_ABORT: begin
                go  = (cur == omcg_pkg::MODE_WASHING);
                tgt = i_req.abort_was_manual ? omcg_pkg::MODE_IDLE
                                             : omcg_pkg::MODE_EXCEPTION;
            end
            omcg_pkg::KIND_POST_WASH: begin
                go  = (cur == omcg_pkg::MODE_IDLE) && i_req.exc_demand;
                tgt = omcg_pkg::MODE_EXCEPTION;
            end
            omcg_pkg::KIND_SELFCHECK_DONE: begin
                go  = (cur == omcg_pkg::MODE_SELFCHECK);
                tgt = i_req.exc_demand ? omcg_pkg::MODE_EXCEPTION : omcg_pkg::MODE_IDLE;
            end
            omcg_pkg::KIND_CRITICAL: begin
                go  = (cur != omcg_pkg::MODE_WASHING) && (cur != omcg_pkg::MODE_RECOVERING);
                tgt = omcg_pkg::MODE_EXCEPTION;
            end
            omcg_pkg::KIND_ESTOP: begin
                o_next.estop = 1'b1;
                go  = 1'b1;
                tgt = omcg_pkg::MODE_EXCEPTION;
            end
            omcg_pkg::KIND_ESTOP_CLEAR: begin
                o_next.estop       = 1'b0;
                o_rsp.context_sync = 1'b1;
            end
            omcg_pkg::KIND_RECOVERY_DONE: begin
                go  = (cur == omcg_pkg::MODE_RECOVERING);
                tgt = i_req.recovery_to_idle ? omcg_pkg::MODE_IDLE
                                             : omcg_pkg::MODE_EXCEPTION;
            end
            omcg_pkg::KIND_FAULT_RESET: begin
                go  = (cur == omcg_pkg::MODE_EXCEPTION);
                tgt = omcg_pkg::MODE_IDLE;
            end
            omcg_pkg::KIND_SERVICE_SET: begin
                o_next.service     = i_req.service_enable;
                o_rsp.context_sync = 1'b1;
            end
            omcg_pkg::KIND_INIT: begin
                // forced to idle, no change flag
                o_next.mode    = omcg_pkg::MODE_IDLE;
                o_next.estop   = 1'b0;
                o_next.service = 1'b1;
            end
            default: ;
        endcase

        if (go) begin
            o_next.mode = tgt;
            changed     = (tgt != cur);
        end

        o_rsp.mode          = o_next.mode;
        o_rsp.mode_changed  = changed;
        o_rsp.estop_latched = o_next.estop;
        o_rsp.service_on    = o_next.service;
        o_rsp.stopping      = !o_next.service ||
                              o_next.mode == omcg_pkg::MODE_INIT ||
                              o_next.mode == omcg_pkg::MODE_EXCEPTION ||
                              o_next.mode == omcg_pkg::MODE_RECOVERING;
        o_rsp.standby       = (o_next.mode == omcg_pkg::MODE_IDLE) && o_next.service;
    end

endmodule

// ===== design/operating_mode_command_gate.sv =====
// Path: the request is registered in the input reg, then its result in the result reg.
// Throughput: one request per cycle while the output is not stalled, set by
//   the combinational step logic reading and updating mode, estop and service regs.
// Stalled output holds its result; input stays open while the result reg drains.
// Reset (sync, active low): mode init, estop clear, service on, both stages empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module operating_mode_command_gate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    omcg_in_if.sink     i_req,
    omcg_out_if.source  o_rsp
);

    // ---- stage registers -------------------------------------------------
    logic             r_in_valid;
    logic             n_in_valid;
    omcg_pkg::t_req   r_in;
    logic             r_out_valid;
    logic             n_out_valid;
    omcg_pkg::t_rsp   r_out;
    omcg_pkg::t_state r_state;

    omcg_pkg::t_state step_next;
    omcg_pkg::t_rsp   step_rsp;

    logic in_fire;
    logic advance;

    // A held request moves into the result register when that register is
    // empty or is being drained this cycle. The state updates on the same edge,
    // so the next request always sees the effect of the one before it.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign in_fire     = i_req.valid && i_req.ready;

    always_comb begin
        n_in_valid  = in_fire ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_valid);
    end

    omcg_step u_step (
        .i_req   (r_in),
        .i_state (r_state),
        .o_next  (step_next),
        .o_rsp   (step_rsp)
    );

    // control and mode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state.mode    <= omcg_pkg::MODE_INIT;
            r_state.estop   <= 1'b0;
            r_state.service <= 1'b1;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= step_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.kind             <= i_req.kind;
            r_in.command          <= i_req.command;
            r_in.alarm_blocking   <= i_req.alarm_blocking;
            r_in.abort_was_manual <= i_req.abort_was_manual;
            r_in.exc_demand       <= i_req.exc_demand;
            r_in.recovery_to_idle <= i_req.recovery_to_idle;
            r_in.service_enable   <= i_req.service_enable;
        end
        if (advance) begin
            r_out <= step_rsp;
        end
    end

    // ---- result channel ---------------------------------------------------
    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.verdict            = r_out.verdict;
    assign o_rsp.reject_reason      = r_out.reject_reason;
    assign o_rsp.mode               = r_out.mode;
    assign o_rsp.previous_mode      = r_out.previous_mode;
    assign o_rsp.mode_changed       = r_out.mode_changed;
    assign o_rsp.recovery_requested = r_out.recovery_requested;
    assign o_rsp.context_sync       = r_out.context_sync;
    assign o_rsp.estop_latched      = r_out.estop_latched;
    assign o_rsp.service_on         = r_out.service_on;
    assign o_rsp.stopping           = r_out.stopping;
    assign o_rsp.standby            = r_out.standby;

    // ---- checks -------------------------------------------------------------
    `ASSERT_PROP(a_rsp_matches_state, i_clk, i_rst_n,
        advance && i_rst_n |=> r_out_valid && r_out.mode == r_state.mode &&
        r_out.estop_latched == r_state.estop && r_out.service_on == r_state.service)
    `ASSERT_PROP(a_state_holds_idle, i_clk, i_rst_n,
        !advance && i_rst_n |=> $stable(r_state))
    `ASSERT_PROP(a_change_differs, i_clk, i_rst_n,
        r_out_valid && r_out.mode_changed |-> r_out.mode != r_out.previous_mode)
    `ASSERT_PROP(a_reason_only_on_deny, i_clk, i_rst_n,
        r_out_valid && r_out.verdict != omcg_pkg::VERDICT_DENIED |->
        r_out.reject_reason == omcg_pkg::REASON_NONE)
    `ASSERT_PROP(a_recover_enters_mode, i_clk, i_rst_n,
        r_out_valid && r_out.recovery_requested |->
        r_out.mode == omcg_pkg::MODE_RECOVERING &&
        r_out.verdict == omcg_pkg::VERDICT_ALLOWED)

endmodule
